@@ rtl/yta_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// yta_pkg
// Shared types and fixed constants of the YUV to ARGB converter with
// 90 degree rotation.
// ----------------------------------------------------------------------------
package yta_pkg;

  // Fixed field widths
  localparam int CFG_W   = 13;  // dimension register width
  localparam int IDX_W   = 24;  // rotated destination index width
  localparam int ARGB_W  = 32;  // packed pixel width
  localparam int CIDX_W  = 8;   // configuration register index width
  localparam int ACC_W   = 22;  // signed accumulator width of one channel

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] REG_FRAME_WIDTH  = 8'd0;
  localparam logic [CIDX_W-1:0] REG_FRAME_HEIGHT = 8'd1;

  // Register reset values
  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 13'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd480;

  // BT.601 integer matrix
  localparam logic signed [ACC_W-1:0] COEF_Y  = 22'sd1192;
  localparam logic signed [ACC_W-1:0] COEF_RV = 22'sd1634;
  localparam logic signed [ACC_W-1:0] COEF_GV = 22'sd833;
  localparam logic signed [ACC_W-1:0] COEF_GU = 22'sd400;
  localparam logic signed [ACC_W-1:0] COEF_BU = 22'sd2066;

  // Offsets, clamp and packing
  localparam logic [7:0]              LUMA_OFS   = 8'd16;
  localparam logic signed [ACC_W-1:0] CHROMA_OFS = 22'sd128;
  localparam logic signed [ACC_W-1:0] CHAN_MAX   = 22'sd262143;
  localparam int                      CHAN_SHIFT = 10;
  localparam logic [7:0]              ALPHA      = 8'hff;

  // One input pixel
  typedef struct packed {
    logic [7:0] chroma_v;
    logic [7:0] chroma_u;
    logic [7:0] luma;
  } pixel_t;

endpackage : yta_pkg
`default_nettype wire

@@ rtl/yta_color.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// yta_color
// Integer BT.601 YUV to packed ARGB conversion of one pixel, combinational.
// ----------------------------------------------------------------------------
module yta_color (
  input  wire yta_pkg::pixel_t        pix,
  output logic [yta_pkg::ARGB_W-1:0]  argb
);
  import yta_pkg::*;

  // Clamp to 0..262143, then take bits 17:10
  function automatic logic [7:0] clamp_chan(input logic signed [ACC_W-1:0] acc);
    logic [7:0] res;
    if (acc < 0) begin
      res = 8'h00;
    end else if (acc > CHAN_MAX) begin
      res = 8'hff;
    end else begin
      res = acc[CHAN_SHIFT+7:CHAN_SHIFT];
    end
    return res;
  endfunction

  logic [7:0]              y_u;
  logic signed [ACC_W-1:0] y_s, u_s, v_s, yy;
  logic signed [ACC_W-1:0] r_acc, g_acc, b_acc;

  // Offsets: luma floored at zero, chroma centered
  always_comb begin
    y_u = (pix.luma < LUMA_OFS) ? 8'd0 : 8'(pix.luma - LUMA_OFS);
    y_s = $signed(ACC_W'(y_u));
    u_s = $signed(ACC_W'(pix.chroma_u)) - CHROMA_OFS;
    v_s = $signed(ACC_W'(pix.chroma_v)) - CHROMA_OFS;
  end

  // Matrix
  always_comb begin
    yy    = COEF_Y * y_s;
    r_acc = yy + COEF_RV * v_s;
    g_acc = yy - COEF_GV * v_s - COEF_GU * u_s;
    b_acc = yy + COEF_BU * u_s;
  end

  assign argb = {ALPHA, clamp_chan(b_acc), clamp_chan(g_acc), clamp_chan(r_acc)};

endmodule : yta_color
`default_nettype wire

@@ rtl/yuv_to_argb_rotate90_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// yuv_to_argb_rotate90_unit
// YUV pixel stream to ARGB words with destination index of a 90 degree
// clockwise rotation and an end-of-frame flag.
// ----------------------------------------------------------------------------
// An input beat passes the input register, then the result register, to out_tvalid.
// Throughput: one pixel per cycle; input register and result register form a
// two-stage pipeline that stalls only while out_tready is low and both hold.
// Reset (rst_n low, synchronous): counters to zero, pipeline emptied,
// frame_width to 640 and frame_height to 480. cfg_ready is always high.
// ----------------------------------------------------------------------------
module yuv_to_argb_rotate90_unit #(
  parameter int MAX_DIM = 4096
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // in_tdata: luma [7:0], chroma_u [15:8], chroma_v [23:16]
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [23:0]                  in_tdata,
  // out_tdata: dest_index [23:0], argb_word [55:24]
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  output logic [55:0]                       out_tdata,
  output logic                              out_tlast,   // frame_end
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [yta_pkg::CIDX_W-1:0]   cfg_index,
  input  wire logic [yta_pkg::CFG_W-1:0]    cfg_data
);
  import yta_pkg::*;

  localparam int CW = $clog2(MAX_DIM);      // counter width
  localparam int DW = $clog2(MAX_DIM + 1);  // effective dimension width

  // Configuration registers
  logic [CFG_W-1:0] width_r, height_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= FRAME_WIDTH_RST;
      height_r <= FRAME_HEIGHT_RST;
    end else if (cfg_valid) begin
      if (cfg_index == REG_FRAME_WIDTH)  width_r  <= cfg_data;
      if (cfg_index == REG_FRAME_HEIGHT) height_r <= cfg_data;
    end
  end

  // Effective dimensions: zero acts as one, clipped to MAX_DIM
  logic [DW-1:0] w_eff, h_eff;

  always_comb begin
    if (width_r == '0)                        w_eff = DW'(1);
    else if (32'(width_r) > 32'(MAX_DIM))     w_eff = DW'(MAX_DIM);
    else                                      w_eff = DW'(width_r);
    if (height_r == '0)                       h_eff = DW'(1);
    else if (32'(height_r) > 32'(MAX_DIM))    h_eff = DW'(MAX_DIM);
    else                                      h_eff = DW'(height_r);
  end

  // Pipeline handshake
  logic s1_valid_r, out_valid_r;
  logic adv2, adv1, in_fire;

  assign adv2      = !out_valid_r || out_tready;
  assign adv1      = !s1_valid_r || adv2;
  assign in_tready = adv1;
  assign in_fire   = in_tvalid && adv1;

  // Raster counters, advanced on each input beat
  logic [CW-1:0] col_r, row_r, col_nxt, row_nxt;
  logic          row_end, last_now;

  always_comb begin
    row_end  = DW'(col_r) >= (w_eff - DW'(1));
    last_now = row_end && (DW'(row_r) >= (h_eff - DW'(1)));
    col_nxt  = col_r;
    row_nxt  = row_r;
    if (last_now) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (row_end) begin
      col_nxt = '0;
      row_nxt = CW'(row_r + 1'b1);
    end else begin
      col_nxt = CW'(col_r + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_fire) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Input register
  pixel_t        pix_s1_r;
  logic [CW-1:0] col_s1_r, row_s1_r;
  logic          last_s1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv1) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      pix_s1_r  <= pixel_t'(in_tdata);
      col_s1_r  <= col_r;
      row_s1_r  <= row_r;
      last_s1_r <= last_now;
    end
  end

  // Conversion and rotated index
  logic [ARGB_W-1:0]  argb_s1;
  logic [CW+DW-1:0]   prod_s1;
  logic [IDX_W-1:0]   idx_s1;

  yta_color u_color (
    .pix  (pix_s1_r),
    .argb (argb_s1)
  );

  always_comb begin
    prod_s1 = (CW+DW)'(col_s1_r) * (CW+DW)'(h_eff);
    idx_s1  = IDX_W'(IDX_W'(prod_s1) + IDX_W'(h_eff) - IDX_W'(row_s1_r) - IDX_W'(1));
  end

  // Result register
  logic [IDX_W-1:0]  idx_out_r;
  logic [ARGB_W-1:0] argb_out_r;
  logic              last_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv2) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && s1_valid_r) begin
      idx_out_r  <= idx_s1;
      argb_out_r <= argb_s1;
      last_out_r <= last_s1_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {argb_out_r, idx_out_r};
  assign out_tlast  = last_out_r;

  // Assertions
  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && last_now) |=> (col_r == '0 && row_r == '0))
    else $error("counters not cleared after last pixel of frame");

  a_s1_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && adv2) |=> out_valid_r)
    else $error("stage-1 pixel lost on its way to the result register");

  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !adv2) |=> (s1_valid_r && $stable(col_s1_r) && $stable(row_s1_r)))
    else $error("stalled stage-1 pixel changed or dropped");

endmodule : yuv_to_argb_rotate90_unit
`default_nettype wire

@@ tb/sv/yuv_to_argb_rotate90_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuv_to_argb_rotate90_unit_tb
// Streams YUV pixels into the converter under several frame geometries and
// checks each ARGB word, rotated destination index and frame-end flag
// against an in-bench BT.601 converter with its own raster counters.
// ----------------------------------------------------------------------------
module yuv_to_argb_rotate90_unit_tb;
  import yta_pkg::*;

  localparam int MAX_DIM    = 4096;
  localparam int PIXEL_GOAL = 700;
  localparam int IDLE_LIMIT = 4000;

  typedef struct packed {
    logic [23:0] dest_index;
    logic [31:0] argb_word;
    logic        frame_end;
  } argb_pixel_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [23:0]         in_tdata = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [55:0]         out_tdata;
  logic                out_tlast;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CIDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]    cfg_data = '0;

  pixel_t      pixel_queue[$];
  argb_pixel_t argb_expected[$];

  // Converter copy: geometry registers and raster counters
  logic [CFG_W-1:0] conv_width;
  logic [CFG_W-1:0] conv_height;
  logic [31:0]      conv_col;
  logic [31:0]      conv_row;

  int error_count = 0;
  int pixels_sent = 0;
  int idle_cycles = 0;
  int stall_mode = 0;
  bit sender_steady = 1'b0;
  int burst_left = 0;
  int gap_left = 0;
  int ready_run = 0;
  logic [10:0] ready_pattern = 11'b10110011101;

  yuv_to_argb_rotate90_unit #(
    .MAX_DIM(MAX_DIM)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // luma [7:0], chroma_u [15:8], chroma_v [23:16]
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // dest_index [23:0], argb_word [55:24]
    .out_tlast  (out_tlast),   // frame_end
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Zero maps to one, anything past the maximum saturates
  function automatic logic [31:0] clip_dim(input logic [CFG_W-1:0] v);
    if (v == 0) return 32'd1;
    if (v > MAX_DIM) return MAX_DIM;
    return {19'd0, v};
  endfunction

  function automatic logic [7:0] clamp_channel(input int acc);
    int a;
    a = acc;
    if (a < 0) a = 0;
    if (a > 262143) a = 262143;
    return 8'(a >>> 10);
  endfunction

  // BT.601 conversion plus rotated index; advances the raster counters
  function automatic argb_pixel_t convert_pixel(input pixel_t px);
    int y, u, v;
    logic [31:0] w, h, idx;
    logic row_end, last_px;
    argb_pixel_t res;
    w = clip_dim(conv_width);
    h = clip_dim(conv_height);
    y = int'(px.luma);
    u = int'(px.chroma_u);
    v = int'(px.chroma_v);
    y = y - 16;
    u = u - 128;
    v = v - 128;
    if (y < 0) y = 0;
    res.argb_word = {8'hff,
                     clamp_channel(1192 * y + 2066 * u),
                     clamp_channel(1192 * y - 833 * v - 400 * u),
                     clamp_channel(1192 * y + 1634 * v)};
    idx = conv_col * h + (h - conv_row - 32'd1);
    res.dest_index = idx[23:0];
    row_end = conv_col >= w - 32'd1;
    last_px = row_end && (conv_row >= h - 32'd1);
    res.frame_end = last_px;
    if (last_px) begin
      conv_col = 0;
      conv_row = 0;
    end else if (row_end) begin
      conv_col = 0;
      conv_row = conv_row + 1;
    end else begin
      conv_col = conv_col + 1;
    end
    return res;
  endfunction

  // Byte source biased toward the clamp and offset corners
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'($urandom_range(13, 19));
      3: return 8'($urandom_range(125, 131));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_dim();
    case ($urandom_range(0, 11))
      0: return 13'd0;
      1: return 13'd4096;
      2: return 13'd4097;
      3: return 13'd8191;
      default: return 13'($urandom_range(1, 8));
    endcase
  endfunction

  task automatic report(input string field, input logic [31:0] exp, input logic [31:0] act);
    $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, field, exp, act);
    error_count++;
  endtask

  // Input driver: bursts of beats separated by random gaps, with no gaps when sender_steady is set
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else if (!in_tvalid || in_tready) begin
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (pixel_queue.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tdata  <= pixel_queue.pop_front();
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 23);
          gap_left = sender_steady ? 0 : $urandom_range(0, 6);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result-side backpressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      case (stall_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 1) == 1);
        2: begin
          out_tready <= ready_pattern[0];
          ready_pattern = {ready_pattern[0], ready_pattern[10:1]};
        end
        default: begin
          if (ready_run == 0) begin
            ready_run = $urandom_range(1, 20);
            out_tready <= ~out_tready;
          end else begin
            ready_run--;
          end
        end
      endcase
    end
  end

  // Monitor: register writes, input beats, result beats, watchdog
  always @(posedge clk) begin
    argb_pixel_t exp_px;
    bit moved;
    moved = 1'b0;
    if (!rst_n) begin
      conv_width  = FRAME_WIDTH_RST;
      conv_height = FRAME_HEIGHT_RST;
      conv_col    = 0;
      conv_row    = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        moved = 1'b1;
        if (cfg_index == REG_FRAME_WIDTH) conv_width = cfg_data;
        else if (cfg_index == REG_FRAME_HEIGHT) conv_height = cfg_data;
      end
      if (in_tvalid && in_tready) begin
        moved = 1'b1;
        argb_expected.push_back(convert_pixel(pixel_t'(in_tdata)));
      end
      if (out_tvalid && out_tready) begin
        moved = 1'b1;
        if (argb_expected.size() == 0) begin
          $display("%0t: unexpected result beat, expected none actual 0x%0h", $time,
                   out_tdata);
          error_count++;
        end else begin
          exp_px = argb_expected.pop_front();
          if (out_tdata[23:0] !== exp_px.dest_index)
            report("dest_index", 32'(exp_px.dest_index), 32'(out_tdata[23:0]));
          if (out_tdata[55:24] !== exp_px.argb_word)
            report("argb_word", exp_px.argb_word, out_tdata[55:24]);
          if (out_tlast !== exp_px.frame_end)
            report("frame_end", 32'(exp_px.frame_end), 32'(out_tlast));
        end
      end
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: watchdog expired with %0d results outstanding", $time,
               argb_expected.size());
      $display("yuv_to_argb_rotate90_unit_tb: FAIL");
      $finish;
    end
  end

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pixel_queue.size() != 0 || in_tvalid || argb_expected.size() != 0);
  endtask

  task automatic push_pixel(input logic [7:0] y, input logic [7:0] u, input logic [7:0] v);
    pixel_t px;
    px.luma = y;
    px.chroma_u = u;
    px.chroma_v = v;
    pixel_queue.push_back(px);
    pixels_sent++;
  endtask

  // New geometry while idle, then a batch of random pixels
  task automatic run_geometry(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                              input int count);
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    @(negedge clk);
    stall_mode = $urandom_range(0, 3);
    sender_steady = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < count; i++) push_pixel(pick_byte(), pick_byte(), pick_byte());
    wait_drained();
  endtask

  initial begin
    logic [CFG_W-1:0] w, h;
    int n, area;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Color corners at reset geometry
    stall_mode = 1;
    push_pixel(8'd0, 8'd0, 8'd0);
    push_pixel(8'd255, 8'd255, 8'd255);
    push_pixel(8'd0, 8'd255, 8'd255);
    push_pixel(8'd255, 8'd0, 8'd0);
    push_pixel(8'd16, 8'd128, 8'd128);
    push_pixel(8'd15, 8'd128, 8'd128);
    push_pixel(8'd17, 8'd128, 8'd128);
    push_pixel(8'd235, 8'd128, 8'd128);
    push_pixel(8'd255, 8'd128, 8'd128);
    push_pixel(8'd0, 8'd128, 8'd128);
    push_pixel(8'd128, 8'd0, 8'd255);
    push_pixel(8'd128, 8'd255, 8'd0);
    push_pixel(8'd81, 8'd90, 8'd240);
    push_pixel(8'd41, 8'd240, 8'd110);
    push_pixel(8'd255, 8'd255, 8'd0);
    push_pixel(8'd255, 8'd0, 8'd255);
    push_pixel(8'd0, 8'd0, 8'd255);
    push_pixel(8'd0, 8'd255, 8'd0);
    wait_drained();

    // Geometry corners
    run_geometry(13'd4, 13'd3, 12);
    run_geometry(13'd0, 13'd0, 3);          // zero acts as one
    run_geometry(13'd8191, 13'd8191, 10);   // saturates to the maximum
    run_geometry(13'd4097, 13'd2, 5);
    run_geometry(13'd3, 13'd2, 8);          // width shrinks under the column
    run_geometry(13'd1, 13'd4096, 30);
    run_geometry(13'd1, 13'd4, 6);          // row already past the new height
    run_geometry(13'd4096, 13'd1, 20);
    run_geometry(13'd4096, 13'd4096, 6);

    // Random geometries; small frames often get a multiple of the frame area in pixels
    while (pixels_sent < PIXEL_GOAL) begin
      w = pick_dim();
      h = pick_dim();
      area = clip_dim(w) * clip_dim(h);
      if (area <= 64 && $urandom_range(0, 3) != 0) n = area * $urandom_range(1, 3);
      else n = $urandom_range(1, 40);
      if (n > 120) n = 120;
      run_geometry(w, h, n);
    end

    repeat (8) @(posedge clk);
    if (argb_expected.size() != 0) begin
      $display("%0t: %0d results never arrived, expected 0 actual %0d", $time,
               argb_expected.size(), argb_expected.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("yuv_to_argb_rotate90_unit_tb: PASS");
    end else begin
      $display("yuv_to_argb_rotate90_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/yta_pkg.sv
rtl/yta_color.sv
rtl/yuv_to_argb_rotate90_unit.sv
tb/sv/yuv_to_argb_rotate90_unit_tb.sv
